// ===== sv/rps_pkg.sv =====
// rps_pkg: shared constants and control types for the ray point sampler
// no dependencies; used by the channel interfaces, the divider and the top level
package rps_pkg;

   localparam int DEFAULT_COORD_WIDTH = 20;
   localparam int DEFAULT_MAX_SAMPLES = 64;

   localparam int STEP_WIDTH = 19;
   localparam logic [STEP_WIDTH-1:0] STEP_RESET = 19'd51;

   localparam int FRAC_BITS = 16;
   // per-axis step magnitude is at most sample_step * 2^FRAC_BITS
   localparam int QUO_WIDTH = STEP_WIDTH + FRAC_BITS;

   localparam int INDEX_WIDTH = 6;
   localparam int CNT_WIDTH = 7;
   localparam int DIV_CNT_WIDTH = 6;

   typedef struct packed {
      logic                     start;
      logic [DIV_CNT_WIDTH-1:0] steps;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== sv/rps_req_if.sv =====
// rps_req_if: input channel of the ray point sampler, one 3d point per transaction
// depends on rps_pkg
interface rps_req_if #(
   parameter int COORD_WIDTH = rps_pkg::DEFAULT_COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input point_z,
                 output ready);
endinterface

// ===== sv/rps_rsp_if.sv =====
// rps_rsp_if: result channel of the ray point sampler, one ray sample per transaction
// depends on rps_pkg
interface rps_rsp_if #(
   parameter int COORD_WIDTH = rps_pkg::DEFAULT_COORD_WIDTH
);
   logic                               valid;
   logic                               ready;
   logic signed [COORD_WIDTH-1:0]      sample_x;
   logic signed [COORD_WIDTH-1:0]      sample_y;
   logic signed [COORD_WIDTH-1:0]      sample_z;
   logic [rps_pkg::INDEX_WIDTH-1:0]    sample_index;
   logic                               last_sample;
   logic                               count_saturated;

   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   output sample_index, output last_sample, output count_saturated,
                   input ready);
   modport sink (input valid, input sample_x, input sample_y, input sample_z,
                 input sample_index, input last_sample, input count_saturated,
                 output ready);
endinterface

// ===== sv/rps_div.sv =====
// rps_div: shared restoring divider, one quotient bit per cycle
// depends on rps_pkg; the caller preloads the partial remainder and dividend bits
module rps_div #(
   parameter int DIVISOR_WIDTH = rps_pkg::STEP_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rps_pkg::div_ctrl_type          ctrl,
   input  logic [DIVISOR_WIDTH-1:0]       rem_init,
   input  logic [rps_pkg::QUO_WIDTH-1:0]  quo_init,
   input  logic [DIVISOR_WIDTH-1:0]       divisor,
   output rps_pkg::div_stat_type          stat,
   output logic [rps_pkg::QUO_WIDTH-1:0]  quotient
);

   localparam int QW = rps_pkg::QUO_WIDTH;

   logic [DIVISOR_WIDTH-1:0]          rem_ff, rem_in;
   logic [QW-1:0]                     quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]          dvs_ff, dvs_in;
   logic [rps_pkg::DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   logic [DIVISOR_WIDTH:0]            trial;
   logic                              fits;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = rem_init;
         quo_in  = quo_init;
         dvs_in  = divisor;
         cnt_in  = ctrl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_WIDTH'(trial - {1'b0, dvs_ff})
                       : trial[DIVISOR_WIDTH-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rps_pkg::DIV_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== sv/ray_point_sampler.sv =====
// ray_point_sampler: top level; samples the ray from a point back to the origin
// depends on rps_pkg, rps_req_if, rps_rsp_if and rps_div
//
// One point is taken at a time; req_ch.ready is low from acceptance until the point's
// last sample has gone into the output register. Set-up is squaring of the three
// coordinates on the shared multiplier, a bit-serial square root, the sample count on
// the shared divider, then per axis a multiply and a division for the step with 16
// fraction bits. The first sample is loaded once set-up is done and the output register
// is free, and the rest follow at one per cycle while rsp_ch.ready is high, and the last
// one may still wait in the output register while the next point is taken. A point
// shorter than one sample_step gives no transaction at all and frees the input once the
// sample count is known (straight after the square root with a zero sample_step).
module ray_point_sampler #(
   parameter int MAX_SAMPLES = rps_pkg::DEFAULT_MAX_SAMPLES,
   parameter int COORD_WIDTH = rps_pkg::DEFAULT_COORD_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [rps_pkg::STEP_WIDTH-1:0]   csr_write_data,
   rps_req_if.sink                          req_ch,
   rps_rsp_if.source                        rsp_ch
);

   localparam int CW   = COORD_WIDTH;
   localparam int SWD  = rps_pkg::STEP_WIDTH;
   localparam int FB   = rps_pkg::FRAC_BITS;
   localparam int QW   = rps_pkg::QUO_WIDTH;
   localparam int CNTW = rps_pkg::CNT_WIDTH;
   localparam int DCW  = rps_pkg::DIV_CNT_WIDTH;
   localparam int VW   = (CW > SWD) ? CW : SWD;
   localparam int PW   = CW + VW;
   localparam int SUMW = 2 * CW;
   localparam int EW   = VW + SWD;
   localparam int AW   = ((CW + FB > QW) ? CW + FB : QW) + 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SQR      = 3'd1;
   localparam logic [2:0] S_SQRT     = 3'd2;
   localparam logic [2:0] S_CNT_GO   = 3'd3;
   localparam logic [2:0] S_CNT_WAIT = 3'd4;
   localparam logic [2:0] S_AMUL     = 3'd5;
   localparam logic [2:0] S_ADIV     = 3'd6;
   localparam logic [2:0] S_EMIT     = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              axis_ff, axis_in;
   logic [DCW-1:0]          iter_ff, iter_in;
   logic [SWD-1:0]          step_ff;
   logic signed [CW-1:0]    pt_ff [3];
   logic signed [CW-1:0]    pt_in [3];
   logic signed [AW-1:0]    acc_ff [3];
   logic signed [AW-1:0]    acc_in [3];
   logic signed [AW-1:0]    d_ff [3];
   logic signed [AW-1:0]    d_in [3];
   logic [SUMW-1:0]         sum_ff, sum_in;
   logic [CW:0]             rem_ff, rem_in;
   logic [CW-1:0]           root_ff, root_in;
   logic [CNTW-1:0]         count_ff, count_in;
   logic                    sat_ff, sat_in;
   logic [CNTW-1:0]         k_ff, k_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]    out_x_ff, out_y_ff, out_z_ff;
   logic signed [CW-1:0]    out_x_in, out_y_in, out_z_in;
   logic [rps_pkg::INDEX_WIDTH-1:0] out_idx_ff, out_idx_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_sat_ff, out_sat_in;

   logic signed [CW-1:0]    pt_sel;
   logic                    neg_sel;
   logic [CW-1:0]           mag_sel;
   logic [VW-1:0]           mul_b;
   logic [PW-1:0]           mul_p;
   logic [EW-1:0]           a_ext;
   logic [CW+2:0]           sq_rem;
   logic [CW+2:0]           sq_trial;
   logic                    sq_fits;
   logic [CW+2:0]           sq_diff;
   logic [CW-1:0]           cnt_full;
   logic                    cnt_sat;
   logic signed [AW-1:0]    q_ext;
   logic                    emit_load;
   logic                    is_last;

   rps_pkg::div_ctrl_type   div_ctrl;
   rps_pkg::div_stat_type   div_stat;
   logic [VW-1:0]           div_rem_init;
   logic [QW-1:0]           div_quo_init;
   logic [VW-1:0]           div_divisor;
   logic [QW-1:0]           div_quo;

   // shared multiplier: squares of the coordinates, then |coord| * sample_step
   assign pt_sel  = pt_ff[axis_ff];
   assign neg_sel = pt_sel[CW-1];
   assign mag_sel = neg_sel ? (~$unsigned(pt_sel) + 1'b1) : $unsigned(pt_sel);
   assign mul_b   = (state_ff == S_SQR) ? VW'(mag_sel) : VW'(step_ff);
   assign mul_p   = PW'(mag_sel) * PW'(mul_b);
   assign a_ext   = EW'(mul_p);

   // square root, two radicand bits a cycle
   assign sq_rem   = {rem_ff, sum_ff[SUMW-1 -: 2]};
   assign sq_trial = (CW + 3)'({root_ff, 2'b01});
   assign sq_fits  = sq_rem >= sq_trial;
   assign sq_diff  = sq_rem - sq_trial;

   assign cnt_full = div_quo[CW-1:0];
   assign cnt_sat  = cnt_full > CW'(MAX_SAMPLES);
   assign q_ext    = $signed(AW'(div_quo));

   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign is_last   = k_ff == (count_ff - 1'b1);

   // divider operands: sample count first, then one axis step at a time
   always_comb begin
      div_ctrl = '0;
      if (state_ff == S_CNT_GO && step_ff != '0) begin
         div_ctrl.start = 1'b1;
         div_ctrl.steps = DCW'(CW);
      end else if (state_ff == S_AMUL) begin
         div_ctrl.start = 1'b1;
         div_ctrl.steps = DCW'(QW);
      end
      if (state_ff == S_AMUL) begin
         div_rem_init = a_ext[SWD +: VW];
         div_quo_init = {a_ext[SWD-1:0], FB'(0)};
         div_divisor  = VW'(root_ff);
      end else begin
         div_rem_init = '0;
         div_quo_init = {root_ff, (QW - CW)'(0)};
         div_divisor  = VW'(step_ff);
      end
   end

   rps_div #(
      .DIVISOR_WIDTH (VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .rem_init (div_rem_init),
      .quo_init (div_quo_init),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      iter_in     = iter_ff;
      pt_in       = pt_ff;
      acc_in      = acc_ff;
      d_in        = d_ff;
      sum_in      = sum_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      count_in    = count_ff;
      sat_in      = sat_ff;
      k_in        = k_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_z_in    = out_z_ff;
      out_idx_in  = out_idx_ff;
      out_last_in = out_last_ff;
      out_sat_in  = out_sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               pt_in[0] = req_ch.point_x;
               pt_in[1] = req_ch.point_y;
               pt_in[2] = req_ch.point_z;
               acc_in[0] = AW'(req_ch.point_x) <<< FB;
               acc_in[1] = AW'(req_ch.point_y) <<< FB;
               acc_in[2] = AW'(req_ch.point_z) <<< FB;
               sum_in   = '0;
               axis_in  = 2'd0;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            sum_in = sum_ff + mul_p[SUMW-1:0];
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               rem_in   = '0;
               root_in  = '0;
               iter_in  = DCW'(CW - 1);
               state_in = S_SQRT;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         S_SQRT: begin
            rem_in  = sq_fits ? sq_diff[CW:0] : sq_rem[CW:0];
            root_in = {root_ff[CW-2:0], sq_fits};
            sum_in  = sum_ff << 2;
            if (iter_ff == '0) begin
               state_in = S_CNT_GO;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         S_CNT_GO: begin
            // zero step gives no samples
            state_in = (step_ff == '0) ? S_IDLE : S_CNT_WAIT;
         end
         S_CNT_WAIT: begin
            if (div_stat.done) begin
               if (cnt_full == '0) begin
                  state_in = S_IDLE;
               end else begin
                  count_in = cnt_sat ? CNTW'(MAX_SAMPLES) : cnt_full[CNTW-1:0];
                  sat_in   = cnt_sat;
                  axis_in  = 2'd0;
                  state_in = S_AMUL;
               end
            end
         end
         S_AMUL: begin
            state_in = S_ADIV;
         end
         S_ADIV: begin
            if (div_stat.done) begin
               // step points back toward the origin
               d_in[axis_ff] = neg_sel ? q_ext : -q_ext;
               if (axis_ff == 2'd2) begin
                  k_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_AMUL;
               end
            end
         end
         S_EMIT: begin
            if (emit_load) begin
               // arithmetic shift of the accumulator is the floor
               out_x_in    = acc_ff[0][FB +: CW];
               out_y_in    = acc_ff[1][FB +: CW];
               out_z_in    = acc_ff[2][FB +: CW];
               out_idx_in  = k_ff[rps_pkg::INDEX_WIDTH-1:0];
               out_last_in = is_last;
               out_sat_in  = sat_ff;
               for (int i = 0; i < 3; i++) begin
                  acc_in[i] = acc_ff[i] + d_ff[i];
               end
               k_in = k_ff + 1'b1;
               if (is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      iter_ff     <= iter_in;
      pt_ff       <= pt_in;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      count_ff    <= count_in;
      sat_ff      <= sat_in;
      k_ff        <= k_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
      out_sat_ff  <= out_sat_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= rps_pkg::STEP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            step_ff <= csr_write_data;
         end
      end
   end

   assign req_ch.ready           = state_ff == S_IDLE;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.sample_x        = out_x_ff;
   assign rsp_ch.sample_y        = out_y_ff;
   assign rsp_ch.sample_z        = out_z_ff;
   assign rsp_ch.sample_index    = out_idx_ff;
   assign rsp_ch.last_sample     = out_last_ff;
   assign rsp_ch.count_saturated = out_sat_ff;

   // divider is never restarted mid-division
   assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // accepting a point drops req_ch.ready
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("input still ready after accepting a point");

   // sample counter never runs past the clipped count
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> k_ff < count_ff)
      else $error("sample index beyond sample count");

   // a loaded sample is offered on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      emit_load |=> rsp_valid_ff)
      else $error("loaded sample not presented");

endmodule
